// ----- hdl/msfa_pkg.sv -----
package msfa_pkg;

	// frame layout
	localparam int unsigned MinFrame   = 31;
	localparam int unsigned StoreBase  = 3;
	localparam int unsigned StoreLast  = 28;
	localparam int unsigned NumFields  = 26;
	localparam int unsigned NumStamps  = 3;
	localparam int unsigned LineLen    = 59;
	localparam logic [5:0]  LastSlot   = 6'(LineLen - 1);

	// year byte positions of the three timestamps
	localparam logic [16:0] PosYear0Hi = 17'd3;
	localparam logic [16:0] PosYear0Lo = 17'd4;
	localparam logic [16:0] PosYear1Hi = 17'd10;
	localparam logic [16:0] PosYear1Lo = 17'd11;
	localparam logic [16:0] PosYear2Hi = 17'd22;
	localparam logic [16:0] PosYear2Lo = 17'd23;

	// ascii characters
	localparam logic [7:0] CharZero  = 8'h30;
	localparam logic [7:0] CharQuery = 8'h3f;
	localparam logic [7:0] CharBang  = 8'h21;
	localparam logic [7:0] CharSpace = 8'h20;

	// result status codes
	localparam logic [1:0] StatOk    = 2'd0;
	localparam logic [1:0] StatSum   = 2'd1;
	localparam logic [1:0] StatShort = 2'd2;

	typedef enum logic {
		ST_COLLECT,
		ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		K_LIT,
		K_TENS,
		K_ONES,
		K_CODE_H,
		K_CODE_T,
		K_CODE_O
	} kind_t;

	typedef enum logic [1:0] {
		SRC_FIELD,
		SRC_YQ,
		SRC_YR
	} src_t;

	typedef struct packed {
		kind_t      kind;
		src_t       src;
		logic [4:0] idx;
		logic [7:0] lit;
	} slot_t;

	// controller to datapath
	typedef struct packed {
		logic       take;
		logic       load_char;
		logic       skip_slot;
		logic       load_err;
		logic [1:0] err_code;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last_pos;
		logic bad_sum;
		logic too_short;
		logic out_free;
		logic slot_skip;
		logic slot_end;
	} dp_stat_t;

	function automatic slot_t lit_e(input logic [7:0] c);
		return slot_t'{kind: K_LIT, src: SRC_FIELD, idx: 5'd0, lit: c};
	endfunction

	function automatic slot_t dig_e(input kind_t k, input src_t s, input logic [4:0] i);
		return slot_t'{kind: k, src: s, idx: i, lit: CharZero};
	endfunction

	// output line script, one entry per character slot
	function automatic slot_t slot_entry(input logic [5:0] slot);
		slot_t e;
		case (slot)
			6'd0:  e = lit_e(CharQuery);
			// boot time
			6'd1:  e = dig_e(K_TENS, SRC_YQ, 5'd0);
			6'd2:  e = dig_e(K_ONES, SRC_YQ, 5'd0);
			6'd3:  e = dig_e(K_TENS, SRC_YR, 5'd0);
			6'd4:  e = dig_e(K_ONES, SRC_YR, 5'd0);
			6'd5:  e = dig_e(K_TENS, SRC_FIELD, 5'd2);
			6'd6:  e = dig_e(K_ONES, SRC_FIELD, 5'd2);
			6'd7:  e = dig_e(K_TENS, SRC_FIELD, 5'd3);
			6'd8:  e = dig_e(K_ONES, SRC_FIELD, 5'd3);
			6'd9:  e = dig_e(K_TENS, SRC_FIELD, 5'd4);
			6'd10: e = dig_e(K_ONES, SRC_FIELD, 5'd4);
			6'd11: e = dig_e(K_TENS, SRC_FIELD, 5'd5);
			6'd12: e = dig_e(K_ONES, SRC_FIELD, 5'd5);
			6'd13: e = dig_e(K_TENS, SRC_FIELD, 5'd6);
			6'd14: e = dig_e(K_ONES, SRC_FIELD, 5'd6);
			6'd15: e = lit_e(CharSpace);
			// stop time
			6'd16: e = dig_e(K_TENS, SRC_YQ, 5'd1);
			6'd17: e = dig_e(K_ONES, SRC_YQ, 5'd1);
			6'd18: e = dig_e(K_TENS, SRC_YR, 5'd1);
			6'd19: e = dig_e(K_ONES, SRC_YR, 5'd1);
			6'd20: e = dig_e(K_TENS, SRC_FIELD, 5'd9);
			6'd21: e = dig_e(K_ONES, SRC_FIELD, 5'd9);
			6'd22: e = dig_e(K_TENS, SRC_FIELD, 5'd10);
			6'd23: e = dig_e(K_ONES, SRC_FIELD, 5'd10);
			6'd24: e = dig_e(K_TENS, SRC_FIELD, 5'd11);
			6'd25: e = dig_e(K_ONES, SRC_FIELD, 5'd11);
			6'd26: e = dig_e(K_TENS, SRC_FIELD, 5'd12);
			6'd27: e = dig_e(K_ONES, SRC_FIELD, 5'd12);
			6'd28: e = dig_e(K_TENS, SRC_FIELD, 5'd13);
			6'd29: e = dig_e(K_ONES, SRC_FIELD, 5'd13);
			6'd30: e = lit_e(CharSpace);
			// run time
			6'd31: e = dig_e(K_TENS, SRC_FIELD, 5'd14);
			6'd32: e = dig_e(K_ONES, SRC_FIELD, 5'd14);
			6'd33: e = dig_e(K_TENS, SRC_FIELD, 5'd15);
			6'd34: e = dig_e(K_ONES, SRC_FIELD, 5'd15);
			6'd35: e = dig_e(K_TENS, SRC_FIELD, 5'd16);
			6'd36: e = dig_e(K_ONES, SRC_FIELD, 5'd16);
			6'd37: e = dig_e(K_TENS, SRC_FIELD, 5'd17);
			6'd38: e = dig_e(K_ONES, SRC_FIELD, 5'd17);
			6'd39: e = lit_e(CharSpace);
			// fault code
			6'd40: e = dig_e(K_CODE_H, SRC_FIELD, 5'd18);
			6'd41: e = dig_e(K_CODE_T, SRC_FIELD, 5'd18);
			6'd42: e = dig_e(K_CODE_O, SRC_FIELD, 5'd18);
			6'd43: e = lit_e(CharSpace);
			// fault time
			6'd44: e = dig_e(K_TENS, SRC_YQ, 5'd2);
			6'd45: e = dig_e(K_ONES, SRC_YQ, 5'd2);
			6'd46: e = dig_e(K_TENS, SRC_YR, 5'd2);
			6'd47: e = dig_e(K_ONES, SRC_YR, 5'd2);
			6'd48: e = dig_e(K_TENS, SRC_FIELD, 5'd21);
			6'd49: e = dig_e(K_ONES, SRC_FIELD, 5'd21);
			6'd50: e = dig_e(K_TENS, SRC_FIELD, 5'd22);
			6'd51: e = dig_e(K_ONES, SRC_FIELD, 5'd22);
			6'd52: e = dig_e(K_TENS, SRC_FIELD, 5'd23);
			6'd53: e = dig_e(K_ONES, SRC_FIELD, 5'd23);
			6'd54: e = dig_e(K_TENS, SRC_FIELD, 5'd24);
			6'd55: e = dig_e(K_ONES, SRC_FIELD, 5'd24);
			6'd56: e = dig_e(K_TENS, SRC_FIELD, 5'd25);
			6'd57: e = dig_e(K_ONES, SRC_FIELD, 5'd25);
			6'd58: e = lit_e(CharBang);
			default: e = lit_e(CharBang);
		endcase
		return e;
	endfunction

endpackage

// ----- hdl/msfa_ctrl.sv -----
module msfa_ctrl import msfa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_COLLECT: begin
				if (in_valid && !(stat.last_pos && !stat.out_free) && stat.last_pos &&
				    !stat.bad_sum && !stat.too_short) begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!stat.slot_skip && stat.out_free && stat.slot_end) begin
					state_nxt = ST_COLLECT;
				end
			end
			default: state_nxt = ST_COLLECT;
		endcase
	end

	// outputs
	always_comb begin
		in_stall      = 1'b1;
		cmd.take      = 1'b0;
		cmd.load_char = 1'b0;
		cmd.skip_slot = 1'b0;
		cmd.load_err  = 1'b0;
		cmd.err_code  = stat.bad_sum ? StatSum : StatShort;
		case (state_q)
			ST_COLLECT: begin
				// the last byte needs a free output register for a possible error
				in_stall     = stat.last_pos && !stat.out_free;
				cmd.take     = in_valid && !in_stall;
				cmd.load_err = cmd.take && stat.last_pos && (stat.bad_sum || stat.too_short);
			end
			ST_EMIT: begin
				cmd.skip_slot = stat.slot_skip;
				cmd.load_char = !stat.slot_skip && stat.out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

// ----- hdl/msfa_dp.sv -----
module msfa_dp import msfa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] data_byte,
	input  dp_cmd_t    cmd,
	output dp_stat_t   stat,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       is_last,
	output logic [1:0] status
);

	// frame tracking
	logic [16:0] byte_count_q;
	logic [15:0] frame_length_q;
	logic [15:0] running_sum_q;
	logic [7:0]  held_byte_q;
	logic [7:0]  field_q [NumFields];
	logic [7:0]  year_hi_q;

	// year split pipeline
	logic        yv_s1;
	logic [1:0]  yid_s1;
	logic [15:0] year_s1;
	logic        yv_s2;
	logic [1:0]  yid_s2;
	logic [15:0] year_s2;
	logic [9:0]  yq_s2;
	logic [6:0]  yq_q [NumStamps];
	logic [6:0]  yr_q [NumStamps];

	// emission
	logic [5:0]  slot_q;
	logic        out_valid_q;
	logic [7:0]  out_char_q;
	logic        is_last_q;
	logic [1:0]  status_q;

	logic [16:0] total;
	logic        pos_ge3;
	logic        held_pos;
	logic        store_hit;
	logic [4:0]  store_idx;
	logic        year_lo_hit;
	logic [1:0]  year_lo_id;
	logic [26:0] q_prod;
	logic [16:0] q_x100;
	logic [15:0] y_rem;
	slot_t       ent;
	logic [7:0]  src_val;
	logic [6:0]  sat_val;
	logic [3:0]  sat_tens;
	logic [3:0]  sat_ones;
	logic [1:0]  code_h;
	logic [6:0]  code_rem;
	logic [3:0]  code_tens;
	logic [3:0]  code_ones;
	logic [7:0]  slot_char;

	// tens and ones of a value below 100
	function automatic logic [7:0] split2(input logic [6:0] v);
		logic [14:0] p;
		logic [3:0]  t;
		logic [6:0]  o;
		p = 15'(v) * 15'd205;
		t = p[14:11];
		o = v - ({3'd0, t} << 3) - ({3'd0, t} << 1);
		return {t, o[3:0]};
	endfunction

	// position decode
	assign total     = {1'b0, frame_length_q} + 17'd5;
	assign pos_ge3   = byte_count_q >= 17'(StoreBase);
	assign held_pos  = pos_ge3 && (byte_count_q + 17'd2 == total);
	assign store_hit = pos_ge3 && (byte_count_q <= 17'(StoreLast));
	assign store_idx = 5'(byte_count_q - 17'(StoreBase));

	assign stat.last_pos  = pos_ge3 && (byte_count_q + 17'd1 == total);
	assign stat.too_short = total < 17'(MinFrame);
	assign stat.bad_sum   = {data_byte, held_byte_q} != running_sum_q;

	always_comb begin
		year_lo_hit = 1'b1;
		year_lo_id  = 2'd0;
		if (byte_count_q == PosYear0Lo) begin
			year_lo_id = 2'd0;
		end else if (byte_count_q == PosYear1Lo) begin
			year_lo_id = 2'd1;
		end else if (byte_count_q == PosYear2Lo) begin
			year_lo_id = 2'd2;
		end else begin
			year_lo_hit = 1'b0;
		end
	end

	// counters, length, checksum and trailer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q   <= '0;
			frame_length_q <= '0;
			running_sum_q  <= '0;
			held_byte_q    <= '0;
		end else if (cmd.take) begin
			if (stat.last_pos) begin
				byte_count_q   <= '0;
				frame_length_q <= '0;
				running_sum_q  <= '0;
				held_byte_q    <= '0;
			end else begin
				byte_count_q <= byte_count_q + 17'd1;
				if (byte_count_q == 17'd1) begin
					frame_length_q <= {data_byte, 8'd0};
				end
				if (byte_count_q == 17'd2) begin
					frame_length_q <= {frame_length_q[15:8], data_byte};
				end
				if (held_pos) begin
					held_byte_q <= data_byte;
				end else begin
					running_sum_q <= running_sum_q + 16'(data_byte);
				end
			end
		end
	end

	// field bytes and year high bytes
	always_ff @(posedge clk) begin
		if (cmd.take && store_hit) begin
			field_q[store_idx] <= data_byte;
		end
		if (cmd.take && (byte_count_q inside {PosYear0Hi, PosYear1Hi, PosYear2Hi})) begin
			year_hi_q <= data_byte;
		end
	end

	// year split: quotient by reciprocal, then remainder
	assign q_prod = 27'(year_s1[15:2]) * 27'd5243;
	assign q_x100 = 17'(yq_s2) * 17'd100;
	assign y_rem  = year_s2 - q_x100[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yv_s1 <= 1'b0;
			yv_s2 <= 1'b0;
		end else begin
			yv_s1 <= cmd.take && year_lo_hit;
			yv_s2 <= yv_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && year_lo_hit) begin
			year_s1 <= {year_hi_q, data_byte};
			yid_s1  <= year_lo_id;
		end
		if (yv_s1) begin
			year_s2 <= year_s1;
			yid_s2  <= yid_s1;
			yq_s2   <= q_prod[26:17];
		end
		if (yv_s2) begin
			yq_q[yid_s2] <= (yq_s2 > 10'd99) ? 7'd99 : yq_s2[6:0];
			yr_q[yid_s2] <= y_rem[6:0];
		end
	end

	// character of the current slot
	assign ent = slot_entry(slot_q);

	always_comb begin
		case (ent.src)
			SRC_FIELD: src_val = field_q[ent.idx];
			SRC_YQ:    src_val = {1'b0, yq_q[ent.idx[1:0]]};
			SRC_YR:    src_val = {1'b0, yr_q[ent.idx[1:0]]};
			default:   src_val = field_q[ent.idx];
		endcase
	end

	assign sat_val = (src_val > 8'd99) ? 7'd99 : src_val[6:0];
	assign {sat_tens, sat_ones} = split2(sat_val);

	always_comb begin
		if (src_val >= 8'd200) begin
			code_h   = 2'd2;
			code_rem = 7'(src_val - 8'd200);
		end else if (src_val >= 8'd100) begin
			code_h   = 2'd1;
			code_rem = 7'(src_val - 8'd100);
		end else begin
			code_h   = 2'd0;
			code_rem = src_val[6:0];
		end
	end

	assign {code_tens, code_ones} = split2(code_rem);

	always_comb begin
		case (ent.kind)
			K_LIT:    slot_char = ent.lit;
			K_TENS:   slot_char = CharZero + 8'(sat_tens);
			K_ONES:   slot_char = CharZero + 8'(sat_ones);
			K_CODE_H: slot_char = CharZero + 8'(code_h);
			K_CODE_T: slot_char = CharZero + 8'(code_tens);
			K_CODE_O: slot_char = CharZero + 8'(code_ones);
			default:  slot_char = ent.lit;
		endcase
	end

	// leading zeros of the fault code are dropped
	assign stat.slot_skip = (ent.kind == K_CODE_H && src_val < 8'd100) ||
	                        (ent.kind == K_CODE_T && src_val < 8'd10);
	assign stat.slot_end  = slot_q == LastSlot;
	assign stat.out_free  = !out_valid_q || !out_stall;

	// slot counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (cmd.take) begin
			slot_q <= '0;
		end else if (cmd.load_char || cmd.skip_slot) begin
			slot_q <= slot_q + 6'd1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_char || cmd.load_err) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_err) begin
			out_char_q <= 8'd0;
			is_last_q  <= 1'b1;
			status_q   <= cmd.err_code;
		end else if (cmd.load_char) begin
			out_char_q <= slot_char;
			is_last_q  <= stat.slot_end;
			status_q   <= StatOk;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign is_last   = is_last_q;
	assign status    = status_q;

endmodule

// ----- hdl/machine_status_frame_to_ascii.sv -----
// Converts a machine status frame, one byte per request, into an ASCII status line
// of 57 to 59 characters, or into one error result for a bad checksum or a frame shorter
// than 31 bytes. While a frame is being received the block takes one byte per clock
// cycle; only the last byte may wait for the output register to drain. After the last
// byte of a good frame the input is stalled and the line is sent from a single output
// register over 59 character slots at one slot per cycle while the output side does not
// stall; each leading zero of the fault code that is dropped leaves the output idle in
// place of its character. The three year values are split into hundreds and remainder
// by a two-stage multiplier pipeline while the frame is still arriving, so the line
// starts right after the trailer. An error result is a single output entry, and the
// next frame may start at once.
module machine_status_frame_to_ascii import msfa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       is_last,
	output logic [1:0] status
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// frame sequencing
	msfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// frame storage, checksum and character formatting
	msfa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (data_byte),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_char  (out_char),
		.is_last   (is_last),
		.status    (status)
	);

endmodule
